// ===== src/rba_pkg.sv =====
package rba_pkg;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [16:0] length;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] offset;
		logic [16:0] used_bytes;
		logic [31:0] full_count;
	} rsp_t;

	typedef struct packed {
		logic [16:0] ring_size;
	} cfg_t;

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} slot_state_t;

	// controller to datapath
	typedef struct packed {
		logic step;
		logic cfg_wr;
	} ctrl_cmd_t;

endpackage

// ===== src/rba_chan_if.sv =====
interface rba_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ring_byte_allocator.sv =====
// Ring byte allocator: offset bookkeeping for a contiguous byte ring.
// Latency: the result is valid in the cycle after the request transfer.
// Throughput: one request per cycle while rsp_ready holds; a request is taken while a
// result waits only if that result is read in the same cycle, as the single result register frees up on the same edge.
// Reset: head, tail, used and full counters clear, ring size returns to
// MAX_RING_BYTES; no clearing pass, ready straight out of reset.
module ring_byte_allocator
	import rba_pkg::*;
#(
	parameter int MAX_RING_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	rba_chan_if.sink   cfg,
	rba_chan_if.sink   req,
	rba_chan_if.source rsp
);

	ctrl_cmd_t cmd;
	rsp_t      rsp_data;

	// Controller owns the handshakes: an output slot that is either empty or
	// holds one result. A request transfer happens whenever the slot is empty
	// or is being drained in the same cycle.
	rba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cmd       (cmd)
	);

	// Datapath: size, head, tail, used and full registers plus the
	// allocate/release decision, all settled in the transfer cycle.
	// Positions are kept 32 bits wide: after a ring size change they may run
	// past the ring end and wrap as plain unsigned words.
	rba_dp #(
		.MAX_RING_BYTES (MAX_RING_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req.data),
		.cfg    (cfg.data),
		.rsp    (rsp_data)
	);

	assign rsp.data = rsp_data;

endmodule

// ===== src/rba_ctrl.sv =====
module rba_ctrl
	import rba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	output ctrl_cmd_t cmd
);

	slot_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b1;
		rsp_valid  = 1'b0;
		cfg_ready  = 1'b1;
		cmd.cfg_wr = cfg_valid;
		cmd.step   = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				req_ready = 1'b1;
				cmd.step  = req_valid;
				if (req_valid) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				cmd.step  = req_valid && rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d   = ST_EMPTY;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/rba_dp.sv =====
module rba_dp
	import rba_pkg::*;
#(
	parameter int MAX_RING_BYTES = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  req_t      req,
	input  cfg_t      cfg,
	output rsp_t      rsp
);

	localparam int SW = $clog2(MAX_RING_BYTES + 1);
	localparam int CW = (SW > 17) ? SW : 17;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RING_BYTES);

	logic [SW-1:0] size_q;
	logic [SW-1:0] used_q;
	logic [31:0]   head_q;
	logic [31:0]   tail_q;
	logic [31:0]   full_q;
	rsp_t          rsp_q;

	logic [CW-1:0] wr_x;
	logic [CW-1:0] wr_eff;
	logic [31:0]   len32, size32, used32, free32;
	logic [31:0]   head_sum, tail_sum, tail_wrap;
	logic          a_bad, a_nofree, a_fit_head, a_fit_zero;
	logic          r_ok;
	logic          ok;
	logic [31:0]   where;
	logic [31:0]   head_d, tail_d, full_d;
	logic [SW-1:0] used_d;

	// ring size write, clamped to 1..MAX
	always_comb begin
		wr_x = CW'(cfg.ring_size);
		if (cfg.ring_size == 17'd0) begin
			wr_eff = CW'(1);
		end else if (wr_x > MAX_C) begin
			wr_eff = MAX_C;
		end else begin
			wr_eff = wr_x;
		end
	end

	always_comb begin
		len32    = 32'(req.length);
		size32   = 32'(size_q);
		used32   = 32'(used_q);
		free32   = (used_q >= size_q) ? 32'd0 : 32'(size_q - used_q);
		head_sum = head_q + len32;
		tail_sum = tail_q + len32;
		tail_wrap = (tail_sum >= size32) ? (tail_sum - size32) : tail_sum;

		a_bad      = (req.length == 17'd0) || (len32 > size32);
		a_nofree   = len32 > free32;
		a_fit_head = head_sum <= size32;
		a_fit_zero = tail_q > len32;
		r_ok       = (req.length != 17'd0) && (len32 <= used32);

		ok     = 1'b0;
		where  = 32'd0;
		head_d = head_q;
		tail_d = tail_q;
		used_d = used_q;
		full_d = full_q;
		if (req.op == OP_ALLOC) begin
			if (a_bad) begin
				ok = 1'b0;
			end else if (a_nofree) begin
				full_d = full_q + 32'd1;
			end else if (a_fit_head) begin
				ok     = 1'b1;
				where  = head_q;
				used_d = SW'(used32 + len32);
				// exact fit wraps head to the start
				head_d = (head_sum == size32) ? 32'd0 : head_sum;
			end else if (a_fit_zero) begin
				// skipped gap at the end stays uncounted
				ok     = 1'b1;
				where  = 32'd0;
				head_d = len32;
				used_d = SW'(used32 + len32);
			end else begin
				full_d = full_q + 32'd1;
			end
		end else begin
			if (r_ok) begin
				ok     = 1'b1;
				tail_d = tail_wrap;
				used_d = SW'(used32 - len32);
				if (used32 == len32) begin
					head_d = tail_wrap;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(MAX_RING_BYTES);
			used_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			full_q <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				size_q <= SW'(wr_eff);
			end
			if (cmd.step) begin
				used_q <= used_d;
				head_q <= head_d;
				tail_q <= tail_d;
				full_q <= full_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rsp_q.ok         <= ok;
			rsp_q.offset     <= ok ? where[15:0] : 16'd0;
			rsp_q.used_bytes <= 17'(32'(used_d));
			rsp_q.full_count <= full_d;
		end
	end

	assign rsp = rsp_q;

endmodule
